// ----- rtl/mrf_pkg.sv -----
// ----------------------------------------------------------------------------
// Modbus RTU response framer package
// Shared types, codes, defaults and the CRC-16/MODBUS byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package mrf_pkg;

    localparam int TABLE_DEPTH_DEF = 128;
    localparam int MAX_READ_DEF    = 16;

    localparam int REQ_W  = 2;
    localparam int BYTE_W = 8;
    localparam int ADDR_W = 7;
    localparam int CNT_W  = 5;
    localparam int REG_W  = 16;
    localparam int IDX_W  = 8;
    localparam int SEL_W  = 4;

    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_EXC   = 2'd2;

    localparam logic [BYTE_W-1:0] SLAVE_ID_RESET = 8'h01;
    localparam logic [BYTE_W-1:0] FUNC_EXC_BIT   = 8'h80;
    localparam logic [REG_W-1:0]  CRC_INIT       = 16'hFFFF;
    localparam logic [REG_W-1:0]  CRC_POLY       = 16'hA001;

    localparam logic [SEL_W-1:0] SEL_SID  = 4'd0;
    localparam logic [SEL_W-1:0] SEL_FUNC = 4'd1;
    localparam logic [SEL_W-1:0] SEL_FEXC = 4'd2;
    localparam logic [SEL_W-1:0] SEL_EXC  = 4'd3;
    localparam logic [SEL_W-1:0] SEL_CNT  = 4'd4;
    localparam logic [SEL_W-1:0] SEL_HI   = 4'd5;
    localparam logic [SEL_W-1:0] SEL_LO   = 4'd6;
    localparam logic [SEL_W-1:0] SEL_CRCL = 4'd7;
    localparam logic [SEL_W-1:0] SEL_CRCH = 4'd8;

    typedef struct packed {
        logic             accept;
        logic             emit;
        logic [SEL_W-1:0] sel;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic left_zero;
        logic left_one;
    } t_sts;

    function automatic logic [REG_W-1:0] crc_add(input logic [REG_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
        logic [REG_W-1:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/mrf_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mrf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mrf_ctrl.sv -----
// ----------------------------------------------------------------------------
// Modbus RTU response framer controller
// Sequences the bytes of a response frame and the request handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module mrf_ctrl (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [mrf_pkg::REQ_W-1:0] i_req_type,
    input  wire mrf_pkg::t_sts            i_sts,
    output mrf_pkg::t_cmd                 o_cmd
);

    import mrf_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SID  = 4'd1;
    localparam logic [3:0] ST_FUNC = 4'd2;
    localparam logic [3:0] ST_EXC  = 4'd3;
    localparam logic [3:0] ST_CNT  = 4'd4;
    localparam logic [3:0] ST_HI   = 4'd5;
    localparam logic [3:0] ST_LO   = 4'd6;
    localparam logic [3:0] ST_CRCL = 4'd7;
    localparam logic [3:0] ST_CRCH = 4'd8;

    logic [3:0] r_state, n_state;
    logic       r_exc, n_exc;
    logic       accept;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && (r_state == ST_IDLE);

    always_comb begin
        n_state      = r_state;
        n_exc        = r_exc;
        o_cmd.accept = accept;
        o_cmd.emit   = 1'b0;
        o_cmd.sel    = SEL_SID;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_req_type == REQ_READ) begin
                        n_state = ST_SID;
                        n_exc   = 1'b0;
                    end else if (i_req_type == REQ_EXC) begin
                        n_state = ST_SID;
                        n_exc   = 1'b1;
                    end
                end
            end
            ST_SID: begin
                o_cmd.sel  = SEL_SID;
                o_cmd.emit = i_sts.out_free;
                if (i_sts.out_free) n_state = ST_FUNC;
            end
            ST_FUNC: begin
                o_cmd.sel  = r_exc ? SEL_FEXC : SEL_FUNC;
                o_cmd.emit = i_sts.out_free;
                if (i_sts.out_free) n_state = r_exc ? ST_EXC : ST_CNT;
            end
            ST_EXC: begin
                o_cmd.sel  = SEL_EXC;
                o_cmd.emit = i_sts.out_free;
                if (i_sts.out_free) n_state = ST_CRCL;
            end
            ST_CNT: begin
                o_cmd.sel  = SEL_CNT;
                o_cmd.emit = i_sts.out_free;
                if (i_sts.out_free) n_state = i_sts.left_zero ? ST_CRCL : ST_HI;
            end
            ST_HI: begin
                o_cmd.sel  = SEL_HI;
                o_cmd.emit = i_sts.out_free;
                if (i_sts.out_free) n_state = ST_LO;
            end
            ST_LO: begin
                o_cmd.sel  = SEL_LO;
                o_cmd.emit = i_sts.out_free;
                if (i_sts.out_free) n_state = i_sts.left_one ? ST_CRCL : ST_HI;
            end
            ST_CRCL: begin
                o_cmd.sel  = SEL_CRCL;
                o_cmd.emit = i_sts.out_free;
                if (i_sts.out_free) n_state = ST_CRCH;
            end
            ST_CRCH: begin
                o_cmd.sel  = SEL_CRCH;
                o_cmd.emit = i_sts.out_free;
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_exc   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_exc   <= n_exc;
        end
    end

    a_crch_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CRCH && i_sts.out_free) |=> (r_state == ST_IDLE))
        else $error("frame did not end after CRC high byte");

    a_exc_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_exc |-> (r_state != ST_HI && r_state != ST_LO && r_state != ST_CNT))
        else $error("exception frame entered data bytes");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |-> !o_cmd.emit)
        else $error("request taken while a frame is in progress");

endmodule

`default_nettype wire

// ----- rtl/mrf_datapath.sv -----
// ----------------------------------------------------------------------------
// Modbus RTU response framer datapath
// Register table, request holding registers, CRC and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mrf_datapath #(
    parameter int TABLE_DEPTH = mrf_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_READ    = mrf_pkg::MAX_READ_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [mrf_pkg::BYTE_W-1:0]  i_cfg_wr_data,
    input  wire logic [mrf_pkg::REQ_W-1:0]   i_req_type,
    input  wire logic [mrf_pkg::BYTE_W-1:0]  i_function_code,
    input  wire logic [mrf_pkg::ADDR_W-1:0]  i_reg_address,
    input  wire logic [mrf_pkg::CNT_W-1:0]   i_reg_count,
    input  wire logic [mrf_pkg::REG_W-1:0]   i_write_value,
    input  wire logic [mrf_pkg::BYTE_W-1:0]  i_exception_code,
    input  wire mrf_pkg::t_cmd               i_cmd,
    output mrf_pkg::t_sts                    o_sts,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic      [mrf_pkg::BYTE_W-1:0]  o_tx_byte,
    output logic                             o_frame_last,
    output logic                             o_out_of_range
);

    import mrf_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IDX_W:0]   DEPTH_LIM = (IDX_W + 1)'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_LIM   = CNT_W'(MAX_READ);

    logic [BYTE_W-1:0]    r_slave_id;
    logic [BYTE_W-1:0]    r_func;
    logic [BYTE_W-1:0]    r_exc_code;
    logic [REG_W-1:0]     r_crc;
    logic [IDX_W-1:0]     r_idx;
    logic [CNT_W-1:0]     r_left;
    logic                 r_rd_hit;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic                 r_out_valid;
    logic [BYTE_W-1:0]    r_out_byte;
    logic                 r_out_last;
    logic                 r_out_oor;

    logic [CNT_W-1:0]     sat_cnt;
    logic [IDX_W-1:0]     wr_idx;
    logic                 wr_en;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_idx;
    logic                 rd_in_range;
    logic                 cur_in_range;
    logic                 emit_lo;
    logic                 emit_data;
    logic [REG_W-1:0]     ram_rdata;
    logic [BYTE_W-1:0]    byte_mux;
    logic                 byte_oor;

    assign sat_cnt      = (i_reg_count > CNT_LIM) ? CNT_LIM : i_reg_count;
    assign wr_idx       = {1'b0, i_reg_address};
    assign wr_en        = i_cmd.accept && (i_req_type == REQ_WRITE) &&
                          ({1'b0, wr_idx} < DEPTH_LIM);
    assign emit_lo      = i_cmd.emit && (i_cmd.sel == SEL_LO);
    assign emit_data    = i_cmd.emit && (i_cmd.sel != SEL_CRCL) && (i_cmd.sel != SEL_CRCH);
    assign rd_en        = i_cmd.accept || emit_lo;
    assign rd_idx       = i_cmd.accept ? wr_idx : r_idx + 1'b1;
    assign rd_in_range  = ({1'b0, rd_idx} < DEPTH_LIM);
    assign cur_in_range = ({1'b0, r_idx} < DEPTH_LIM);

    mrf_ram #(
        .WIDTH(REG_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(wr_idx[AW-1:0]),
        .i_wdata(i_write_value),
        .i_re   (rd_en && rd_in_range),
        .i_raddr(rd_idx[AW-1:0]),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        case (i_cmd.sel)
            SEL_SID:  byte_mux = r_slave_id;
            SEL_FUNC: byte_mux = r_func;
            SEL_FEXC: byte_mux = r_func | FUNC_EXC_BIT;
            SEL_EXC:  byte_mux = r_exc_code;
            SEL_CNT:  byte_mux = BYTE_W'({r_left, 1'b0});
            SEL_HI:   byte_mux = r_rd_hit ? ram_rdata[15:8] : '0;
            SEL_LO:   byte_mux = r_rd_hit ? ram_rdata[7:0] : '0;
            SEL_CRCL: byte_mux = r_crc[7:0];
            SEL_CRCH: byte_mux = r_crc[15:8];
            default:  byte_mux = '0;
        endcase
    end

    assign byte_oor = ((i_cmd.sel == SEL_HI) || (i_cmd.sel == SEL_LO)) && !cur_in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_id  <= SLAVE_ID_RESET;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_slave_id <= i_cfg_wr_data;
            end
            if (wr_en) begin
                r_valid[wr_idx[AW-1:0]] <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func     <= i_function_code;
            r_exc_code <= i_exception_code;
            r_left     <= sat_cnt;
            r_crc      <= CRC_INIT;
        end else if (emit_data) begin
            r_crc <= crc_add(r_crc, byte_mux);
        end
        if (emit_lo) begin
            r_left <= r_left - 1'b1;
        end
        if (rd_en) begin
            r_idx    <= rd_idx;
            r_rd_hit <= rd_in_range && r_valid[rd_idx[AW-1:0]];
        end
        if (i_cmd.emit) begin
            r_out_byte <= byte_mux;
            r_out_last <= (i_cmd.sel == SEL_CRCH);
            r_out_oor  <= byte_oor;
        end
    end

    assign o_sts.out_free  = !r_out_valid || !i_out_stall;
    assign o_sts.left_zero = (r_left == '0);
    assign o_sts.left_one  = (r_left == CNT_W'(1));

    assign o_out_valid    = r_out_valid;
    assign o_tx_byte      = r_out_byte;
    assign o_frame_last   = r_out_last;
    assign o_out_of_range = r_out_oor;

    a_last_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> !r_out_oor)
        else $error("out-of-range flag on final frame byte");

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || !i_out_stall))
        else $error("byte emitted over a held output");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && byte_oor) |-> (byte_mux == '0))
        else $error("register past the table returned non-zero data");

endmodule

`default_nettype wire

// ----- rtl/modbus_rtu_response_framer_top.sv -----
// After a request is taken, the first frame byte passes the state register
// and then the output register. Throughput: one byte per cycle while the output
// is not stalled, set by the single output register. Writes send no frame.
// Reset: table valid bits cleared at once (table reads as zero), slave id 1.
// ----------------------------------------------------------------------------
// Modbus RTU response framer top level
// Frames read and exception responses with CRC-16/MODBUS from a register table.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_response_framer_top #(
    parameter int TABLE_DEPTH = mrf_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_READ    = mrf_pkg::MAX_READ_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [mrf_pkg::BYTE_W-1:0]  i_cfg_wr_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [mrf_pkg::REQ_W-1:0]   i_req_type,
    input  wire logic [mrf_pkg::BYTE_W-1:0]  i_function_code,
    input  wire logic [mrf_pkg::ADDR_W-1:0]  i_reg_address,
    input  wire logic [mrf_pkg::CNT_W-1:0]   i_reg_count,
    input  wire logic [mrf_pkg::REG_W-1:0]   i_write_value,
    input  wire logic [mrf_pkg::BYTE_W-1:0]  i_exception_code,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic      [mrf_pkg::BYTE_W-1:0]  o_tx_byte,
    output logic                             o_frame_last,
    output logic                             o_out_of_range
);

    import mrf_pkg::*;

    t_cmd cmd;
    t_sts sts;

    mrf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_req_type(i_req_type),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    mrf_datapath #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .MAX_READ   (MAX_READ)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_req_type      (i_req_type),
        .i_function_code (i_function_code),
        .i_reg_address   (i_reg_address),
        .i_reg_count     (i_reg_count),
        .i_write_value   (i_write_value),
        .i_exception_code(i_exception_code),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_tx_byte       (o_tx_byte),
        .o_frame_last    (o_frame_last),
        .o_out_of_range  (o_out_of_range)
    );

endmodule

`default_nettype wire
